FILE: hdl/dkfc_pkg.sv
// Shared types and constants for the distinct key frame counter.
`timescale 1ns / 1ps
package dkfc_pkg;

    localparam int SERIAL_W = 24;
    localparam int IDX_W    = 6;
    localparam int FRAMES_W = 32;
    localparam int TOTAL_W  = 7;
    localparam int OUTC_W   = 3;

    localparam logic REQ_NOTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [OUTC_W-1:0] OC_COUNTED    = 3'd0;
    localparam logic [OUTC_W-1:0] OC_INSERTED   = 3'd1;
    localparam logic [OUTC_W-1:0] OC_DROPPED    = 3'd2;
    localparam logic [OUTC_W-1:0] OC_READ_OK    = 3'd3;
    localparam logic [OUTC_W-1:0] OC_READ_EMPTY = 3'd4;

    typedef struct packed {
        logic                kind;
        logic [SERIAL_W-1:0] serial;
        logic [IDX_W-1:0]    index;
    } req_t;

    typedef struct packed {
        logic [OUTC_W-1:0]   outcome;
        logic [IDX_W-1:0]    pos;
        logic [SERIAL_W-1:0] serial;
        logic [FRAMES_W-1:0] frames;
        logic [TOTAL_W-1:0]  total;
    } result_t;

endpackage

FILE: hdl/distinct_key_frame_counter.sv
// Top level of the distinct key frame counter.
// Usage:
//   Slave channel s_*: one request per transfer. tuser selects the request
//   (0 note a serial, 1 read an entry); tdata carries serial and index.
//   Master channel m_*: exactly one result per request, in request order.
//   tuser carries the outcome; tdata carries position, serial, frame count
//   and the number of distinct serials held.
// Operation:
//   A note request walks the filled entries one per cycle through the
//   single read port of the serial/count memories, up to the matching
//   position, or the last filled position when no entry matches. A note
//   into an empty table and a read beyond the fill level need no memory
//   read. The engine takes a new request only when idle with its result
//   register free, so each note or read is finished before the next starts.
// Reset: the table is emptied (fill level cleared); no clearing pass.
// Stall: a held result stops the engine; up to three further requests are
//   absorbed by the input register and queue before s_tready drops.
`timescale 1ns / 1ps
module distinct_key_frame_counter
    import dkfc_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // serial[23:0], index[29:24], zero[31:30]
    input  logic [0:0]  s_tuser,  // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // entry_pos[5:0], entry_serial[29:6],
                                  // entry_frames[61:30], distinct_total[68:62], zero
    output logic [2:0]  m_tuser   // outcome[2:0]
);

    logic    push_valid;
    logic    push_ready;
    req_t    push_req;
    logic    pop_valid;
    logic    pop_ready;
    req_t    pop_req;
    result_t res;

    dkfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    dkfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    dkfc_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (pop_valid),
        .req_ready (pop_ready),
        .req       (pop_req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tuser = res.outcome;
    assign m_tdata = {3'b000, res.total, res.frames, res.serial, res.pos};

endmodule

FILE: hdl/dkfc_front.sv
// Input stage: takes request transfers, decodes them and hands them to the queue.
`timescale 1ns / 1ps
module dkfc_front
    import dkfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output logic        push_valid,
    input  logic        push_ready,
    output req_t        push_req
);

    logic hold_valid_reg;
    logic hold_valid_next;
    req_t hold_reg;
    req_t dec_req;

    always_comb
    begin
        dec_req.kind   = (s_tuser[0] == REQ_READ) ? REQ_READ : REQ_NOTE;
        dec_req.serial = s_tdata[SERIAL_W-1:0];
        dec_req.index  = s_tdata[SERIAL_W+IDX_W-1:SERIAL_W];
    end

    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_req   = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg && !push_ready;
        if (s_tvalid && s_tready)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            hold_reg <= dec_req;
        end
    end

endmodule

FILE: hdl/dkfc_queue.sv
// Two-entry request queue between the input stage and the table engine.
`timescale 1ns / 1ps
module dkfc_queue
    import dkfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  req_t push_req,
    output logic pop_valid,
    input  logic pop_ready,
    output req_t pop_req
);

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_req    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

FILE: hdl/dkfc_engine.sv
// Table engine: serial/count memories, linear search, update and result register.
`timescale 1ns / 1ps
module dkfc_engine
    import dkfc_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  req_t    req,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [SERIAL_W-1:0] key_mem [CAPACITY];
    logic [FRAMES_W-1:0] cnt_mem [CAPACITY];
    logic [SERIAL_W-1:0] key_rd_reg;
    logic [FRAMES_W-1:0] cnt_rd_reg;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CW-1:0]       fill_reg;
    logic [CW-1:0]       fill_next;
    logic [AW-1:0]       issue_reg;
    logic [AW-1:0]       issue_next;
    req_t                req_reg;
    req_t                req_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             out_reg;
    result_t             out_next;

    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [SERIAL_W-1:0] wr_key;
    logic [FRAMES_W-1:0] wr_cnt;
    logic                slot_free;
    logic [FRAMES_W-1:0] cnt_inc;

    assign slot_free = !out_valid_reg || res_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cnt_inc   = cnt_rd_reg + FRAMES_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        rd_addr        = issue_reg;
        mem_we         = 1'b0;
        wr_addr        = issue_reg;
        wr_key         = req_reg.serial;
        wr_cnt         = FRAMES_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && slot_free)
                begin
                    req_next = req;
                    if (req.kind == REQ_READ)
                    begin
                        if (IW'(req.index) < IW'(fill_reg))
                        begin
                            rd_addr    = AW'(req.index);
                            issue_next = AW'(req.index);
                            state_next = ST_READ;
                        end
                        else
                        begin
                            out_valid_next   = 1'b1;
                            out_next.outcome = OC_READ_EMPTY;
                            out_next.pos     = '0;
                            out_next.serial  = '0;
                            out_next.frames  = '0;
                            out_next.total   = TOTAL_W'(fill_reg);
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        mem_we           = 1'b1;
                        wr_addr          = '0;
                        wr_key           = req.serial;
                        fill_next        = CW'(1);
                        out_valid_next   = 1'b1;
                        out_next.outcome = OC_INSERTED;
                        out_next.pos     = '0;
                        out_next.serial  = req.serial;
                        out_next.frames  = FRAMES_W'(1);
                        out_next.total   = TOTAL_W'(1);
                    end
                    else
                    begin
                        rd_addr    = '0;
                        issue_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (key_rd_reg == req_reg.serial)
                begin
                    mem_we           = 1'b1;
                    wr_addr          = issue_reg;
                    wr_key           = key_rd_reg;
                    wr_cnt           = cnt_inc;
                    out_valid_next   = 1'b1;
                    out_next.outcome = OC_COUNTED;
                    out_next.pos     = IDX_W'(issue_reg);
                    out_next.serial  = key_rd_reg;
                    out_next.frames  = cnt_inc;
                    out_next.total   = TOTAL_W'(fill_reg);
                    state_next       = ST_IDLE;
                end
                else if (CW'(issue_reg) + CW'(1) == fill_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (fill_reg < CW'(CAPACITY))
                    begin
                        mem_we           = 1'b1;
                        wr_addr          = fill_reg[AW-1:0];
                        wr_key           = req_reg.serial;
                        fill_next        = fill_reg + CW'(1);
                        out_next.outcome = OC_INSERTED;
                        out_next.pos     = IDX_W'(fill_reg);
                        out_next.serial  = req_reg.serial;
                        out_next.frames  = FRAMES_W'(1);
                        out_next.total   = TOTAL_W'(fill_reg + CW'(1));
                    end
                    else
                    begin
                        out_next.outcome = OC_DROPPED;
                        out_next.pos     = '0;
                        out_next.serial  = '0;
                        out_next.frames  = '0;
                        out_next.total   = TOTAL_W'(fill_reg);
                    end
                end
                else
                begin
                    issue_next = issue_reg + AW'(1);
                    rd_addr    = issue_reg + AW'(1);
                end
            end
            ST_READ:
            begin
                out_valid_next   = 1'b1;
                out_next.outcome = OC_READ_OK;
                out_next.pos     = req_reg.index;
                out_next.serial  = key_rd_reg;
                out_next.frames  = cnt_rd_reg;
                out_next.total   = TOTAL_W'(fill_reg);
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg <= issue_next;
        req_reg   <= req_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr] <= wr_key;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        key_rd_reg <= key_mem[rd_addr];
        cnt_rd_reg <= cnt_mem[rd_addr];
    end

endmodule

FILE: tb/distinct_key_frame_counter_tb.sv
// Self-checking testbench for the distinct key frame counter.
`timescale 1ns / 1ps
module distinct_key_frame_counter_tb;
    import dkfc_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct packed {
        logic                kind;
        logic [SERIAL_W-1:0] serial;
        logic [IDX_W-1:0]    index;
        logic                typed;
        result_t             want;
    } probe_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    // predictor state
    logic [SERIAL_W-1:0] held_serial [CAPACITY];
    logic [FRAMES_W-1:0] held_frames [CAPACITY];
    int                  held_count;

    result_t    awaited_results [$];
    probe_row_t probe_rows [$];
    int         outcome_seen [5];
    int         fault_count;
    int         quiet_cycles;
    int         stall_left;
    bit         calm;

    distinct_key_frame_counter #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Search in insertion order, count on a hit, append while room remains; answer reads from the held entries.
    function automatic result_t tally_request(input logic kind, input logic [SERIAL_W-1:0] ser,
                                              input logic [IDX_W-1:0] idx);
        result_t          r;
        bit               hit;
        logic [IDX_W-1:0] slot;
        hit = 1'b0;
        r   = '0;
        if (kind == REQ_NOTE)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                slot = i[IDX_W-1:0];
                if (!hit && held_serial[slot] == ser)
                begin
                    hit               = 1'b1;
                    held_frames[slot] = held_frames[slot] + 1'b1;
                    r.outcome         = OC_COUNTED;
                    r.pos             = slot;
                    r.serial          = held_serial[slot];
                    r.frames          = held_frames[slot];
                end
            end
            if (!hit)
            begin
                if (held_count < CAPACITY)
                begin
                    slot              = held_count[IDX_W-1:0];
                    held_serial[slot] = ser;
                    held_frames[slot] = FRAMES_W'(1);
                    r.outcome = OC_INSERTED;
                    r.pos     = slot;
                    r.serial  = ser;
                    r.frames  = FRAMES_W'(1);
                    held_count++;
                end
                else
                begin
                    r.outcome = OC_DROPPED;
                end
            end
        end
        else if (int'(idx) < held_count)
        begin
            r.outcome = OC_READ_OK;
            r.pos     = idx;
            r.serial  = held_serial[idx];
            r.frames  = held_frames[idx];
        end
        else
        begin
            r.outcome = OC_READ_EMPTY;
        end
        r.total = held_count[TOTAL_W-1:0];
        outcome_seen[r.outcome]++;
        return r;
    endfunction

    task automatic add_row(input logic kind, input logic [SERIAL_W-1:0] ser,
                           input logic [IDX_W-1:0] idx, input logic typed,
                           input logic [OUTC_W-1:0] oc, input logic [IDX_W-1:0] pos,
                           input logic [SERIAL_W-1:0] w_ser, input logic [FRAMES_W-1:0] frames,
                           input logic [TOTAL_W-1:0] total);
        probe_row_t row;
        row.kind         = kind;
        row.serial       = ser;
        row.index        = idx;
        row.typed        = typed;
        row.want.outcome = oc;
        row.want.pos     = pos;
        row.want.serial  = w_ser;
        row.want.frames  = frames;
        row.want.total   = total;
        probe_rows.push_back(row);
    endtask

    task automatic issue_request(input logic kind, input logic [SERIAL_W-1:0] ser,
                                 input logic [IDX_W-1:0] idx, input logic typed,
                                 input result_t typed_want);
        int      gap;
        result_t want;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, idx, ser};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        want = tally_request(kind, ser, idx);
        if (typed)
            want = typed_want;
        awaited_results.push_back(want);
    endtask

    task automatic check_result(input logic [2:0] oc, input logic [71:0] d);
        result_t want;
        if (awaited_results.size() == 0)
        begin
            $error("result transfer with no request outstanding");
            fault_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            if (oc !== want.outcome)
            begin
                $error("outcome: expected %0d, got %0d", want.outcome, oc);
                fault_count++;
            end
            if (d[5:0] !== want.pos)
            begin
                $error("entry_pos: expected %0d, got %0d", want.pos, d[5:0]);
                fault_count++;
            end
            if (d[29:6] !== want.serial)
            begin
                $error("entry_serial: expected %h, got %h", want.serial, d[29:6]);
                fault_count++;
            end
            if (d[61:30] !== want.frames)
            begin
                $error("entry_frames: expected %0d, got %0d", want.frames, d[61:30]);
                fault_count++;
            end
            if (d[68:62] !== want.total)
            begin
                $error("distinct_total: expected %0d, got %0d", want.total, d[68:62]);
                fault_count++;
            end
        end
    endtask

    // result side: check each transfer, then decide the next tready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(m_tuser, m_tdata);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, awaited_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int                  roll;
        logic                kind;
        logic [SERIAL_W-1:0] ser;
        logic [IDX_W-1:0]    idx;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        held_count   = 0;
        fault_count  = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        calm         = 1'b0;
        foreach (outcome_seen[i])
            outcome_seen[i] = 0;

        // empty table, extremes of serial and index, ignored fields set
        add_row(REQ_READ, 24'h000000,  0, 1, OC_READ_EMPTY, 0, 24'h000000, 0, 0);
        add_row(REQ_READ, 24'hFFFFFF, 63, 1, OC_READ_EMPTY, 0, 24'h000000, 0, 0);
        add_row(REQ_NOTE, 24'h000000, 63, 1, OC_INSERTED,   0, 24'h000000, 1, 1);
        add_row(REQ_NOTE, 24'hFFFFFF,  0, 1, OC_INSERTED,   1, 24'hFFFFFF, 1, 2);
        add_row(REQ_NOTE, 24'h000000,  0, 1, OC_COUNTED,    0, 24'h000000, 2, 2);
        add_row(REQ_NOTE, 24'hFFFFFF, 63, 1, OC_COUNTED,    1, 24'hFFFFFF, 2, 2);
        add_row(REQ_READ, 24'h000000,  1, 1, OC_READ_OK,    1, 24'hFFFFFF, 2, 2);
        add_row(REQ_READ, 24'h000000,  2, 1, OC_READ_EMPTY, 0, 24'h000000, 0, 2);
        add_row(REQ_NOTE, 24'hA5A5A5, 21, 1, OC_INSERTED,   2, 24'hA5A5A5, 1, 3);
        add_row(REQ_NOTE, 24'h5A5A5A, 42, 1, OC_INSERTED,   3, 24'h5A5A5A, 1, 4);
        add_row(REQ_NOTE, 24'h5A5A5A,  0, 1, OC_COUNTED,    3, 24'h5A5A5A, 2, 4);
        add_row(REQ_READ, 24'h123456,  3, 1, OC_READ_OK,    3, 24'h5A5A5A, 2, 4);
        add_row(REQ_READ, 24'h000000,  0, 1, OC_READ_OK,    0, 24'h000000, 2, 4);
        add_row(REQ_READ, 24'h000000,  4, 1, OC_READ_EMPTY, 0, 24'h000000, 0, 4);
        add_row(REQ_NOTE, 24'h800001,  0, 0, OC_COUNTED,    0, 24'h000000, 0, 0);
        add_row(REQ_NOTE, 24'h7FFFFE,  0, 0, OC_COUNTED,    0, 24'h000000, 0, 0);
        add_row(REQ_NOTE, 24'h800001,  0, 0, OC_COUNTED,    0, 24'h000000, 0, 0);
        add_row(REQ_READ, 24'h000000,  5, 0, OC_COUNTED,    0, 24'h000000, 0, 0);
        add_row(REQ_READ, 24'h000000, 32, 0, OC_COUNTED,    0, 24'h000000, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i])
            issue_request(probe_rows[i].kind, probe_rows[i].serial, probe_rows[i].index,
                          probe_rows[i].typed, probe_rows[i].want);

        // mostly notes, many repeating held serials, so the table fills and then drops
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 150 && n < 230);
            if (n == 300)
            begin
                s_tvalid <= 1'b0;
                while (awaited_results.size() != 0) @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            ser  = SERIAL_W'($urandom_range(0, 24'hFFFFFF));
            idx  = IDX_W'($urandom_range(0, 63));
            kind = REQ_NOTE;
            if (roll < 25)
            begin
                kind = REQ_READ;
                if (held_count > 0 && $urandom_range(0, 1) == 1)
                    idx = IDX_W'($urandom_range(0, held_count - 1));
            end
            else if (roll < 65 && held_count > 0)
                ser = held_serial[IDX_W'($urandom_range(0, held_count - 1))];
            else if (roll < 75 && held_count > 0)
                ser = held_serial[IDX_W'($urandom_range(0, held_count - 1))]
                      ^ (24'h1 << $urandom_range(0, SERIAL_W - 1));
            issue_request(kind, ser, idx, 1'b0, '0);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        $display("notes: %0d counted, %0d inserted, %0d dropped with %0d of %0d entries held",
                 outcome_seen[OC_COUNTED], outcome_seen[OC_INSERTED],
                 outcome_seen[OC_DROPPED], held_count, CAPACITY);
        $display("reads: %0d of held entries, %0d beyond the fill level; %0d field mismatches",
                 outcome_seen[OC_READ_OK], outcome_seen[OC_READ_EMPTY], fault_count);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
